>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL controller (udpb_ctrl)
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping-free implication: cons is checked in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_AT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

>>> rtl/udpb_pkg.sv
// ---------------------------------------------------------------------------
// udpb_pkg - shared types and constants of the UDP port binding table
// Word formats, command/status/action codes and reset values.
// ---------------------------------------------------------------------------
package udpb_pkg;

	localparam int DEF_TABLE_DEPTH = 16;
	localparam int DEF_TAG_BITS    = 8;

	localparam logic [15:0] EPH_FIRST_RST = 16'd49152;
	localparam logic [15:0] EPH_LAST_RST  = 16'd65535;
	localparam logic [15:0] CURSOR_RST    = 16'd49152;

	localparam logic [1:0] CMD_BIND     = 2'd0;
	localparam logic [1:0] CMD_BIND_ANY = 2'd1;
	localparam logic [1:0] CMD_UNBIND   = 2'd2;
	localparam logic [1:0] CMD_LOOKUP   = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_BOUND   = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_NOPORT  = 3'd4;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_DELIVER = 2'd1;
	localparam logic [1:0] ACT_UNREACH = 2'd2;
	localparam logic [1:0] ACT_DROP    = 2'd3;

	localparam logic REG_EPH_FIRST = 1'b0;
	localparam logic REG_EPH_LAST  = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] port;
		logic [7:0]  handler_tag;
		logic        address_family;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] port_out;
		logic [7:0]  found_tag;
		logic [1:0]  action;
	} rsp_t;

	typedef struct packed {
		logic [15:0] first;
		logic [15:0] last;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic look;
		logic exec;
	} ctl_t;

	typedef struct packed {
		logic rescan;
	} stat_t;

endpackage

>>> rtl/udp_port_binding_table_unit.sv
// ---------------------------------------------------------------------------
// udp_port_binding_table_unit - UDP port binding table
// Bind, unbind and lookup: look-up then execute, then a registered result strobe; busy holds off a new word until then.
// Bind any: each candidate port visited takes a look-up and an execute state, at most TABLE_DEPTH+2 candidates
// (or the range size if smaller), set by the shared match and the controller loop.
// Reset: table empty, cursor 49152, range 49152..65535; no clearing pass needed.
// ---------------------------------------------------------------------------
module udp_port_binding_table_unit #(
	parameter int TABLE_DEPTH = udpb_pkg::DEF_TABLE_DEPTH,
	parameter int TAG_BITS    = udpb_pkg::DEF_TAG_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	input  logic           start,
	output logic           busy,
	input  udpb_pkg::req_t request,
	output logic           done,
	output udpb_pkg::rsp_t response
);
	import udpb_pkg::*;

	cfg_t  cfg;
	ctl_t  ctl;
	stat_t stat;

	udpb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	udpb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctl    (ctl)
	);

	udpb_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.cfg      (cfg),
		.request  (request),
		.done     (done),
		.response (response)
	);

endmodule

>>> rtl/udpb_cfg.sv
// ---------------------------------------------------------------------------
// udpb_cfg - APB register file
// Holds the ephemeral range limits; register index is paddr[2].
// ---------------------------------------------------------------------------
module udpb_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output udpb_pkg::cfg_t    cfg
);
	import udpb_pkg::*;

	logic [15:0] first_q;
	logic [15:0] last_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= EPH_FIRST_RST;
			last_q  <= EPH_LAST_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_EPH_FIRST: first_q <= pwdata[15:0];
				REG_EPH_LAST:  last_q  <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_EPH_FIRST: prdata = {16'd0, first_q};
			REG_EPH_LAST:  prdata = {16'd0, last_q};
		endcase
	end

	assign cfg.first = first_q;
	assign cfg.last  = last_q;

endmodule

>>> rtl/udpb_ctrl.sv
// ---------------------------------------------------------------------------
// udpb_ctrl - command sequencer
// Idle / look-up / execute; loops back to look-up while bind-any scans.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module udpb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  udpb_pkg::stat_t stat,
	output udpb_pkg::ctl_t  ctl
);
	import udpb_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (start) begin
				state_nx = S_LOOK;
			end
			S_LOOK: state_nx = S_EXEC;
			S_EXEC: state_nx = stat.rescan ? S_LOOK : S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign ctl.load = (state_q == S_IDLE) && start;
	assign ctl.look = (state_q == S_LOOK);
	assign ctl.exec = (state_q == S_EXEC);

	`ASSERT_NEXT(a_accept_to_look, clk, arst_n, ctl.load, state_q == S_LOOK, "accept did not start look-up")
	`ASSERT_NEXT(a_look_to_exec, clk, arst_n, ctl.look, state_q == S_EXEC, "look-up not followed by execute")
	`ASSERT_NEXT(a_exec_to_idle, clk, arst_n, ctl.exec && !stat.rescan, state_q == S_IDLE, "finished word left controller busy")

endmodule

>>> rtl/udpb_dp.sv
// ---------------------------------------------------------------------------
// udpb_dp - binding table datapath
// Parallel port match, free-slot search, tag memory, cursor and result word.
// ---------------------------------------------------------------------------
module udpb_dp #(
	parameter int TABLE_DEPTH = udpb_pkg::DEF_TABLE_DEPTH,
	parameter int TAG_BITS    = udpb_pkg::DEF_TAG_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  udpb_pkg::ctl_t  ctl,
	output udpb_pkg::stat_t stat,
	input  udpb_pkg::cfg_t  cfg,
	input  udpb_pkg::req_t  request,
	output logic            done,
	output udpb_pkg::rsp_t  response
);
	import udpb_pkg::*;

	localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	req_t                  req_q;
	logic [TAG_BITS-1:0]   tag_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [15:0]           port_q [TABLE_DEPTH];
	logic [TAG_BITS-1:0]   tag_mem [TABLE_DEPTH];
	logic [15:0]           cand_q;
	logic [16:0]           cnt_q;
	logic                  hit_q;
	logic                  free_q;
	logic [IdxW-1:0]       hit_idx_q;
	logic [IdxW-1:0]       free_idx_q;
	logic [TAG_BITS-1:0]   rd_tag_q;
	rsp_t                  rsp_q;
	logic                  done_q;

	logic [TAG_BITS+7:0]   tag_ext;
	logic [TAG_BITS-1:0]   tag_in;
	logic [TAG_BITS+7:0]   found_ext;
	logic [15:0]           key;
	logic [TABLE_DEPTH-1:0] match;
	logic                  hit;
	logic [IdxW-1:0]       hit_idx;
	logic                  any_free;
	logic [IdxW-1:0]       free_idx;
	logic [16:0]           span;
	logic [16:0]           cnt_nx;
	logic [15:0]           cand_adv;
	logic                  is_any;
	logic                  scan_ok;
	logic                  cand_free;
	logic                  cand_out;
	rsp_t                  rsp_nx;
	logic                  do_store;
	logic                  do_clear;
	logic [15:0]           store_port;

	// only the low TAG_BITS of the handler tag are kept
	assign tag_ext   = {{TAG_BITS{1'b0}}, request.handler_tag};
	assign tag_in    = tag_ext[TAG_BITS-1:0];
	assign found_ext = {8'd0, rd_tag_q};

	assign is_any = (req_q.command == CMD_BIND_ANY);
	assign key    = is_any ? cand_q : req_q.port;

	// ports are unique among valid entries, so at most one match bit is set
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = valid_q[i] && (port_q[i] == key) && (key != 16'd0);
			if (match[i]) begin
				hit_idx = hit_idx | IdxW'(i);
			end
		end
		hit = |match;
	end

	always_comb begin
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IdxW'(i);
			end
		end
		any_free = ~&valid_q;
	end

	assign span      = {1'b0, cfg.last} - {1'b0, cfg.first} + 17'd1;
	assign cnt_nx    = cnt_q + 17'd1;
	assign cand_adv  = (cand_q == cfg.last) ? cfg.first : cand_q + 16'd1;
	assign scan_ok   = (tag_q != '0) && (cfg.first <= cfg.last);
	assign cand_free = (cand_q != 16'd0) && !hit_q;
	assign cand_out  = (cand_q < cfg.first) || (cand_q > cfg.last);

	assign stat.rescan = is_any && scan_ok && !cand_free && (cnt_nx != span);

	always_comb begin
		rsp_nx.status    = ST_OK;
		rsp_nx.port_out  = req_q.port;
		rsp_nx.found_tag = 8'd0;
		rsp_nx.action    = ACT_NONE;
		do_store         = 1'b0;
		do_clear         = 1'b0;
		store_port       = req_q.port;
		unique case (req_q.command)
			CMD_BIND: begin
				if (req_q.port == 16'd0 || tag_q == '0) begin
					rsp_nx.status = ST_INVALID;
				end else if (hit_q) begin
					rsp_nx.status = ST_BOUND;
				end else if (!free_q) begin
					rsp_nx.status = ST_FULL;
				end else begin
					do_store = 1'b1;
				end
			end
			CMD_BIND_ANY: begin
				rsp_nx.port_out = 16'd0;
				if (tag_q == '0) begin
					rsp_nx.status = ST_INVALID;
				end else if (cfg.first > cfg.last) begin
					rsp_nx.status = ST_NOPORT;
				end else if (cand_free) begin
					if (free_q) begin
						do_store        = 1'b1;
						store_port      = cand_q;
						rsp_nx.port_out = cand_q;
					end else begin
						rsp_nx.status = ST_FULL;
					end
				end else begin
					// range exhausted
					rsp_nx.status = ST_NOPORT;
				end
			end
			CMD_UNBIND: begin
				do_clear = hit_q;
			end
			CMD_LOOKUP: begin
				if (hit_q) begin
					rsp_nx.found_tag = found_ext[7:0];
					rsp_nx.action    = ACT_DELIVER;
				end else begin
					rsp_nx.action = req_q.address_family ? ACT_DROP : ACT_UNREACH;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cand_q  <= CURSOR_RST;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			req_q   <= '0;
			tag_q   <= '0;
		end else begin
			done_q <= ctl.exec && !stat.rescan;
			if (ctl.load) begin
				cnt_q <= '0;
				req_q <= request;
				tag_q <= tag_in;
				if (request.command == CMD_BIND_ANY && tag_in != '0 &&
				    cfg.first <= cfg.last && cand_out) begin
					cand_q <= cfg.first;
				end
			end
			if (ctl.exec && is_any && scan_ok) begin
				cnt_q  <= cnt_nx;
				cand_q <= cand_adv;
			end
			if (ctl.exec && do_store) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (ctl.exec && do_clear) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.look) begin
			hit_q      <= hit;
			hit_idx_q  <= hit_idx;
			free_q     <= any_free;
			free_idx_q <= free_idx;
		end
		if (ctl.exec && do_store) begin
			port_q[free_idx_q] <= store_port;
		end
		if (ctl.exec && !stat.rescan) begin
			rsp_q <= rsp_nx;
		end
	end

	// tag store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.exec && do_store) begin
			tag_mem[free_idx_q] <= tag_q;
		end
		if (ctl.look) begin
			rd_tag_q <= tag_mem[hit_idx];
		end
	end

	assign done     = done_q;
	assign response = rsp_q;

endmodule

>>> tb/udpb_bind_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// udpb_bind_checker - scoreboard for the UDP port binding table
// Follows register writes and accepted request words, keeps its own copy of
// the binding table and cursor, and compares every response word in order.
// ---------------------------------------------------------------------------
module udpb_bind_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	input  logic           pready,
	input  logic           start,
	input  logic           busy,
	input  udpb_pkg::req_t request,
	input  logic           done,
	input  udpb_pkg::rsp_t response,
	output int             fail_count,
	output int             outstanding
);
	import udpb_pkg::*;

	localparam int         TBL_DEPTH = DEF_TABLE_DEPTH;
	localparam int         TAG_W     = DEF_TAG_BITS;
	localparam logic [7:0] TAG_KEEP  = 8'((64'd1 << TAG_W) - 1);

	logic        tbl_valid [TBL_DEPTH];
	logic [15:0] tbl_port  [TBL_DEPTH];
	logic [7:0]  tbl_tag   [TBL_DEPTH];
	logic [15:0] cursor;
	logic [15:0] range_lo;
	logic [15:0] range_hi;
	rsp_t        pending_replies [$];
	int          reported;

	// port 0 never matches
	function automatic int slot_of_port(input logic [15:0] p);
		int idx;
		idx = -1;
		if (p != 16'd0)
			for (int i = TBL_DEPTH - 1; i >= 0; i--)
				if (tbl_valid[i] && tbl_port[i] == p)
					idx = i;
		return idx;
	endfunction

	// lowest free slot, -1 when full
	function automatic int free_slot();
		int idx;
		idx = -1;
		for (int i = TBL_DEPTH - 1; i >= 0; i--)
			if (!tbl_valid[i])
				idx = i;
		return idx;
	endfunction

	task automatic fill_slot(input int slot, input logic [15:0] p, input logic [7:0] tg);
		tbl_valid[slot] = 1'b1;
		tbl_port[slot]  = p;
		tbl_tag[slot]   = tg;
	endtask

	task automatic bind_table_outcome(input req_t r, output rsp_t o);
		int          slot;
		int unsigned span;
		logic [15:0] cand;
		logic [7:0]  tg;
		bit          settled;
		tg          = r.handler_tag & TAG_KEEP;
		o.status    = ST_OK;
		o.port_out  = r.port;
		o.found_tag = 8'd0;
		o.action    = ACT_NONE;
		case (r.command)
			CMD_BIND: begin
				if (r.port == 16'd0 || tg == 8'd0) begin
					o.status = ST_INVALID;
				end else if (slot_of_port(r.port) >= 0) begin
					o.status = ST_BOUND;
				end else begin
					slot = free_slot();
					if (slot < 0)
						o.status = ST_FULL;
					else
						fill_slot(slot, r.port, tg);
				end
			end
			CMD_BIND_ANY: begin
				o.port_out = 16'd0;
				if (tg == 8'd0) begin
					o.status = ST_INVALID;
				end else if (range_lo > range_hi) begin
					o.status = ST_NOPORT;
				end else begin
					span     = int'(range_hi) - int'(range_lo) + 1;
					o.status = ST_NOPORT;
					settled  = 1'b0;
					if (cursor < range_lo || cursor > range_hi)
						cursor = range_lo;
					// cursor steps past every candidate it looks at
					for (int unsigned n = 0; n < span && !settled; n++) begin
						cand   = cursor;
						cursor = (cand == range_hi) ? range_lo : cand + 16'd1;
						if (cand != 16'd0 && slot_of_port(cand) < 0) begin
							settled = 1'b1;
							slot    = free_slot();
							if (slot < 0) begin
								o.status = ST_FULL;
							end else begin
								fill_slot(slot, cand, tg);
								o.status   = ST_OK;
								o.port_out = cand;
							end
						end
					end
				end
			end
			CMD_UNBIND: begin
				slot = slot_of_port(r.port);
				if (slot >= 0)
					tbl_valid[slot] = 1'b0;
			end
			CMD_LOOKUP: begin
				slot = slot_of_port(r.port);
				if (slot >= 0) begin
					o.found_tag = tbl_tag[slot];
					o.action    = ACT_DELIVER;
				end else begin
					o.action = r.address_family ? ACT_DROP : ACT_UNREACH;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < TBL_DEPTH; i++)
				tbl_valid[i] = 1'b0;
			cursor   = CURSOR_RST;
			range_lo = EPH_FIRST_RST;
			range_hi = EPH_LAST_RST;
			pending_replies.delete();
			reported    = 0;
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_EPH_FIRST)
					range_lo = pwdata[15:0];
				else
					range_hi = pwdata[15:0];
			end
			if (start && !busy) begin
				bind_table_outcome(request, want);
				pending_replies.push_back(want);
			end
			if (done) begin
				if (pending_replies.size() == 0) begin
					fail_count++;
					if (reported < 10)
						$display("%0t: unexpected response word st=%0d port=%0d tag=%0d act=%0d",
							$realtime, response.status, response.port_out,
							response.found_tag, response.action);
					reported++;
				end else begin
					want = pending_replies.pop_front();
					if (response.status !== want.status || response.port_out !== want.port_out ||
					    response.found_tag !== want.found_tag || response.action !== want.action) begin
						fail_count++;
						if (reported < 10)
							$display("%0t: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								$realtime,
								want.status, want.port_out, want.found_tag, want.action,
								response.status, response.port_out, response.found_tag,
								response.action);
						reported++;
					end
				end
			end
			outstanding = pending_replies.size();
		end
	end

endmodule

>>> tb/tb_udp_port_binding_table_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_udp_port_binding_table_unit - testbench for the UDP port binding table
// Directed words at reset settings, then random bind, bind-any, unbind and
// lookup traffic over a series of ephemeral ranges, with random idling in most phases.
// ---------------------------------------------------------------------------
module tb_udp_port_binding_table_unit;
	import udpb_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 9;
	localparam int PER_PHASE   = 75;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = 3'd0;
	logic [31:0] pwdata  = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        start   = 1'b0;
	logic        busy;
	req_t        request = '0;
	logic        done;
	rsp_t        response;
	int          fail_count;
	int          outstanding;

	int range_lo = EPH_FIRST_RST;
	int range_hi = EPH_LAST_RST;
	bit idle_on  = 1'b1;
	int stall;

	always #4 clk = ~clk;

	udp_port_binding_table_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response)
	);

	udpb_bind_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.done        (done),
		.response    (response),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// entered and left on a falling edge; start stays high for a back-to-back word
	task automatic send_word(input req_t r);
		while (idle_on && $urandom_range(0, 99) < 35) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do
			@(posedge clk);
		while (!(start && !busy));
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [1:0] cmd, input logic [15:0] p,
			input logic [7:0] tg, input logic fam);
		req_t r;
		r.command        = cmd;
		r.port           = p;
		r.handler_tag    = tg;
		r.address_family = fam;
		send_word(r);
	endtask

	// setup then access; caller drops psel afterwards
	task automatic write_reg(input logic idx, input logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
	endtask

	task automatic drain_block();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic req_t random_request(input bit filling);
		req_t r;
		int   pick;
		int   reach;
		pick = $urandom_range(0, 99);
		if (filling)
			r.command = pick < 45 ? CMD_BIND : pick < 75 ? CMD_BIND_ANY :
				pick < 80 ? CMD_UNBIND : CMD_LOOKUP;
		else
			r.command = pick < 15 ? CMD_BIND : pick < 25 ? CMD_BIND_ANY :
				pick < 65 ? CMD_UNBIND : CMD_LOOKUP;
		// a small pool of ports keeps hits, duplicates and a full table common
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			r.port = 16'($urandom_range(1, 16));
		end else if (pick < 70 && range_lo <= range_hi) begin
			reach  = (range_hi - range_lo < 31) ? range_hi - range_lo : 31;
			r.port = 16'(range_lo + $urandom_range(0, reach));
		end else if (pick < 80) begin
			case ($urandom_range(0, 3))
				0: r.port = 16'd0;
				1: r.port = 16'hFFFF;
				2: r.port = 16'h8000;
				default: r.port = 16'd1;
			endcase
		end else begin
			r.port = 16'($urandom());
		end
		pick = $urandom_range(0, 99);
		r.handler_tag    = pick < 8 ? 8'd0 : pick < 15 ? 8'hFF : 8'($urandom_range(1, 255));
		r.address_family = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// watchdog: cycles with no word, register write or response moved
	always @(posedge clk) begin
		if (!arst_n) begin
			stall = 0;
		end else if ((start && !busy) || done || (psel && penable && pready)) begin
			stall = 0;
		end else begin
			stall++;
			if (stall >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain_block();
				case (ph)
					1: begin range_lo = 1000;  range_hi = 1003;  end
					2: begin range_lo = 1;     range_hi = 65535; end
					3: begin range_lo = 65535; range_hi = 65535; end
					4: begin range_lo = 1;     range_hi = 1;     end
					5: begin range_lo = 3000;  range_hi = 3040;  end
					6: begin range_lo = 500;   range_hi = 400;   end
					7: begin
						range_lo = $urandom_range(1, 65495);
						range_hi = range_lo + $urandom_range(0, 40);
					end
					default: begin range_lo = EPH_FIRST_RST; range_hi = EPH_LAST_RST; end
				endcase
				write_reg(REG_EPH_FIRST, 16'(range_lo));
				write_reg(REG_EPH_LAST, 16'(range_hi));
				psel    <= 1'b0;
				penable <= 1'b0;
				pwrite  <= 1'b0;
				@(negedge clk);
			end else begin
				// zero port or tag, duplicate, hit and miss per family, bind-any, unbinds
				send_fields(CMD_BIND, 16'd0, 8'd5, 1'b0);
				send_fields(CMD_BIND, 16'd100, 8'd0, 1'b0);
				send_fields(CMD_BIND, 16'hFFFF, 8'hFF, 1'b1);
				send_fields(CMD_BIND, 16'hFFFF, 8'd7, 1'b0);
				send_fields(CMD_LOOKUP, 16'hFFFF, 8'd0, 1'b0);
				send_fields(CMD_LOOKUP, 16'd0, 8'd0, 1'b1);
				send_fields(CMD_LOOKUP, 16'd0, 8'd0, 1'b0);
				send_fields(CMD_LOOKUP, 16'd1234, 8'd0, 1'b0);
				send_fields(CMD_LOOKUP, 16'd1234, 8'd0, 1'b1);
				send_fields(CMD_BIND_ANY, 16'd0, 8'd0, 1'b0);
				send_fields(CMD_BIND_ANY, 16'hFFFF, 8'd1, 1'b0);
				send_fields(CMD_BIND_ANY, 16'd0, 8'h80, 1'b1);
				send_fields(CMD_LOOKUP, 16'd49152, 8'hFF, 1'b1);
				send_fields(CMD_UNBIND, 16'd9999, 8'd0, 1'b0);
				send_fields(CMD_UNBIND, 16'hFFFF, 8'd0, 1'b0);
				send_fields(CMD_LOOKUP, 16'hFFFF, 8'd0, 1'b1);
				send_fields(CMD_UNBIND, 16'd0, 8'd3, 1'b1);
			end
			idle_on = !(ph == 2 || ph == 5);
			for (int n = 0; n < PER_PHASE; n++)
				send_word(random_request(((n / 25) % 2) == 0));
		end

		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/udpb_pkg.sv
rtl/udpb_cfg.sv
rtl/udpb_ctrl.sv
rtl/udpb_dp.sv
rtl/udp_port_binding_table_unit.sv
tb/udpb_bind_checker.sv
tb/tb_udp_port_binding_table_unit.sv
